// File: src/fwmt_pkg.sv
// Shared types and constants for the fee window minimum tracker.
// Used by the controller, datapath, top level and checker; no dependencies.
`default_nettype none

package fwmt_pkg;

  // Field widths
  localparam int unsigned FEE_W      = 51;
  localparam int unsigned HEIGHT_W   = 31;
  localparam int unsigned WIN_W      = 9;
  localparam int unsigned CNT_OUT_W  = 9;
  localparam int unsigned ENTRY_W    = 2 * FEE_W + HEIGHT_W;

  // Stream payload widths (fields packed from bit 0, padded to bytes)
  localparam int unsigned IN_FIELDS_W  = ENTRY_W;
  localparam int unsigned IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int unsigned OUT_FIELDS_W = 2 * FEE_W + 2 * CNT_OUT_W + 2;
  localparam int unsigned OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Output field offsets
  localparam int unsigned OUT_MIN_REQ_LSB = FEE_W;
  localparam int unsigned OUT_COUNT_LSB   = 2 * FEE_W;
  localparam int unsigned OUT_MERGED_BIT  = OUT_COUNT_LSB + CNT_OUT_W;
  localparam int unsigned OUT_REMOVED_LSB = OUT_MERGED_BIT + 1;
  localparam int unsigned OUT_OVF_BIT     = OUT_REMOVED_LSB + CNT_OUT_W;

  // Config port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = FEE_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HEIGHT_MODE  = 3'd0,
    CFG_WINDOW_SIZE  = 3'd1,
    CFG_SEED_FT_FEE  = 3'd2,
    CFG_SEED_REQ_FEE = 3'd3,
    CFG_SEED_HEIGHT  = 3'd4
  } cfg_idx_e;

  localparam int unsigned STORE_DEPTH_DEF = 256;

  localparam logic [FEE_W-1:0] FEE_MAX = {FEE_W{1'b1}};

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MATCH,
    ST_APPEND,
    ST_TRIM,
    ST_PURGE_INIT,
    ST_PURGE,
    ST_MIN_INIT,
    ST_MIN,
    ST_OUT
  } state_e;

  // Controller -> datapath
  typedef struct packed {
    logic load;          // take request, seed store on first step
    logic scan_clr;      // rewind scan pointers, reset minima
    logic scan_rd;       // issue next store read of the scan
    logic merge_wr;      // write min-merged entry on height hit
    logic append;        // append request entry (forced drop when full)
    logic trim;          // window mode: drop oldest beyond window
    logic purge_wr;      // height mode: compact kept entries
    logic purge_commit;  // take compacted count
    logic min_acc;       // fold returned entry into minima
    logic out_load;      // present result
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic height_mode;
    logic issue_done;    // all live entries read out
    logic rd_vld;        // store read data valid this cycle
    logic hit;           // returned entry height matches request
    logic out_free;      // result register can take a new result
  } status_t;

endpackage

`default_nettype wire

// File: src/fee_window_minimum_tracker.sv
// Fee window minimum tracker, top level: joins sequencer and datapath.
// Each request is worked through by one-read-per-cycle scans of the N live entries
// (at most STORE_DEPTH): window mode runs the minimum scan only, height mode also
// the match and purge scans; a height merge skips the append and purge.
// Throughput: one request at a time; the next is taken the cycle after the result
// is registered. Reset: async, active low; store contents stay undefined.
`default_nettype none

module fee_window_minimum_tracker #(
  parameter int unsigned STORE_DEPTH = fwmt_pkg::STORE_DEPTH_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // Config write port
  input  wire logic                             cfg_we_i,
  input  wire logic [fwmt_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [fwmt_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  // Request stream
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // ft_fee[50:0], req_fee[101:51], block_height[132:102], zero pad
  input  wire logic [fwmt_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // Result stream
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // min_ft_fee[50:0], min_req_fee[101:51], entry_count[110:102], merged[111],
  // removed_count[120:112], overflow[121], zero pad
  output logic      [fwmt_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import fwmt_pkg::*;

  cmd_t    cmd;
  status_t st;

  fwmt_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .st_i          (st),
    .cmd_o         (cmd)
  );

  fwmt_dpath #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cmd_i         (cmd),
    .st_o          (st)
  );

endmodule

`default_nettype wire

// File: src/fwmt_ram.sv
// Generic single write port, single read port RAM with registered read.
// Standalone; no package dependency.
`default_nettype none

module fwmt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// File: src/fwmt_ctrl.sv
// Sequencer for the fee window minimum tracker: walks each request through
// match, append, trim or purge, and minimum passes. Depends on fwmt_pkg.
`default_nettype none

module fwmt_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  input  wire fwmt_pkg::status_t st_i,
  output fwmt_pkg::cmd_t        cmd_o
);
  import fwmt_pkg::*;

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    s_axis_tready = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          cmd_o.load = 1'b1;
          state_d    = st_i.height_mode ? ST_MATCH : ST_APPEND;
        end
      end
      ST_MATCH: begin
        cmd_o.scan_rd  = 1'b1;
        cmd_o.merge_wr = 1'b1;
        if (st_i.hit) begin
          state_d = ST_MIN_INIT;
        end else if (st_i.issue_done && !st_i.rd_vld) begin
          state_d = ST_APPEND;
        end
      end
      ST_APPEND: begin
        cmd_o.append = 1'b1;
        state_d      = st_i.height_mode ? ST_PURGE_INIT : ST_TRIM;
      end
      ST_TRIM: begin
        cmd_o.trim = 1'b1;
        state_d    = ST_MIN_INIT;
      end
      ST_PURGE_INIT: begin
        cmd_o.scan_clr = 1'b1;
        state_d        = ST_PURGE;
      end
      ST_PURGE: begin
        cmd_o.scan_rd  = 1'b1;
        cmd_o.purge_wr = 1'b1;
        if (st_i.issue_done && !st_i.rd_vld) begin
          cmd_o.purge_commit = 1'b1;
          state_d            = ST_MIN_INIT;
        end
      end
      ST_MIN_INIT: begin
        cmd_o.scan_clr = 1'b1;
        state_d        = ST_MIN;
      end
      ST_MIN: begin
        cmd_o.scan_rd = 1'b1;
        cmd_o.min_acc = 1'b1;
        if (st_i.issue_done && !st_i.rd_vld) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (st_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// File: src/fwmt_dpath.sv
// Datapath of the fee window minimum tracker: config registers, circular
// entry store (fwmt_ram), scan pointers, minima and result register.
// Depends on fwmt_pkg and fwmt_ram.
`default_nettype none

module fwmt_dpath #(
  parameter int unsigned STORE_DEPTH = fwmt_pkg::STORE_DEPTH_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [fwmt_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [fwmt_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  wire logic [fwmt_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  output logic      [fwmt_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  input  wire fwmt_pkg::cmd_t                    cmd_i,
  output fwmt_pkg::status_t                      st_o
);
  import fwmt_pkg::*;

  localparam int unsigned AW = $clog2(STORE_DEPTH);
  localparam int unsigned CW = $clog2(STORE_DEPTH + 1);
  localparam int unsigned XW = (CW > WIN_W) ? CW : WIN_W;

  // Circular index: (base + off) mod depth, base < depth and off <= depth
  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                            input logic [CW-1:0] off);
    logic [CW:0] sum;
    sum = {{(CW + 1 - AW){1'b0}}, base} + {1'b0, off};
    if (sum >= (CW + 1)'(STORE_DEPTH)) begin
      sum = sum - (CW + 1)'(STORE_DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  // Config registers
  logic                mode_q;
  logic [WIN_W-1:0]    win_q;
  logic [FEE_W-1:0]    seed_ft_q, seed_req_q;
  logic [HEIGHT_W-1:0] seed_h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= 1'b0;
      win_q      <= WIN_W'(1);
      seed_ft_q  <= '0;
      seed_req_q <= '0;
      seed_h_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_HEIGHT_MODE:  mode_q     <= cfg_data_i[0];
        CFG_WINDOW_SIZE:  win_q      <= cfg_data_i[WIN_W-1:0];
        CFG_SEED_FT_FEE:  seed_ft_q  <= cfg_data_i[FEE_W-1:0];
        CFG_SEED_REQ_FEE: seed_req_q <= cfg_data_i[FEE_W-1:0];
        CFG_SEED_HEIGHT:  seed_h_q   <= cfg_data_i[HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // Zero window acts as one
  logic [WIN_W-1:0] weff;
  assign weff = (win_q == '0) ? WIN_W'(1) : win_q;

  // Request fields
  logic [FEE_W-1:0]    it_ft_q, it_req_q;
  logic [HEIGHT_W-1:0] it_h_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      it_ft_q  <= s_axis_tdata[FEE_W-1:0];
      it_req_q <= s_axis_tdata[2*FEE_W-1:FEE_W];
      it_h_q   <= s_axis_tdata[ENTRY_W-1:2*FEE_W];
    end
  end

  // Store read side
  logic [AW-1:0]       raddr;
  logic [ENTRY_W-1:0]  rdata;
  logic [FEE_W-1:0]    rd_ft, rd_req;
  logic [HEIGHT_W-1:0] rd_h;

  assign rd_ft  = rdata[FEE_W-1:0];
  assign rd_req = rdata[2*FEE_W-1:FEE_W];
  assign rd_h   = rdata[ENTRY_W-1:2*FEE_W];

  // Control state
  logic          seeded_q, seeded_d;
  logic [AW-1:0] oldest_q, oldest_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] removed_q, removed_d;
  logic          merged_q, merged_d;
  logic          ovf_q, ovf_d;
  logic [CW-1:0] rd_i_q, rd_i_d;
  logic          rd_vld_q, rd_vld_d;
  logic [AW-1:0] rd_slot_q, rd_slot_d;
  logic [CW-1:0] kept_q, kept_d;
  logic [FEE_W-1:0] min_ft_q, min_ft_d, min_req_q, min_req_d;

  // Status toward the controller
  logic hit, keep, issue_done;
  assign issue_done = (rd_i_q == count_q);
  assign hit        = rd_vld_q && (rd_h == it_h_q);
  assign keep = ({1'b0, rd_h} + (HEIGHT_W + 1)'(weff)) > {1'b0, it_h_q};

  assign st_o.height_mode = mode_q;
  assign st_o.issue_done  = issue_done;
  assign st_o.rd_vld      = rd_vld_q;
  assign st_o.hit         = hit;
  assign st_o.out_free    = !m_axis_tvalid || m_axis_tready;

  // Trim arithmetic (window mode)
  logic [XW-1:0] cnt_x, win_x;
  logic [CW-1:0] excess;
  assign cnt_x  = XW'(count_q);
  assign win_x  = XW'(weff);
  assign excess = CW'(cnt_x - win_x);

  // Store write side
  logic               we;
  logic [AW-1:0]      waddr;
  logic [ENTRY_W-1:0] wdata;
  logic               full;
  assign full = (count_q == CW'(STORE_DEPTH));

  always_comb begin
    seeded_d  = seeded_q;
    oldest_d  = oldest_q;
    count_d   = count_q;
    removed_d = removed_q;
    merged_d  = merged_q;
    ovf_d     = ovf_q;
    rd_i_d    = rd_i_q;
    rd_vld_d  = 1'b0;
    rd_slot_d = rd_slot_q;
    kept_d    = kept_q;
    min_ft_d  = min_ft_q;
    min_req_d = min_req_q;
    raddr     = slot_of(oldest_q, rd_i_q);
    we        = 1'b0;
    waddr     = slot_of(oldest_q, count_q);
    wdata     = {it_h_q, it_req_q, it_ft_q};

    // Scan rewind
    if (cmd_i.load || cmd_i.scan_clr) begin
      rd_i_d    = '0;
      kept_d    = '0;
      min_ft_d  = FEE_MAX;
      min_req_d = FEE_MAX;
    end

    // Take request; seed the store on the first step after reset
    if (cmd_i.load) begin
      removed_d = '0;
      merged_d  = 1'b0;
      ovf_d     = 1'b0;
      if (!seeded_q) begin
        seeded_d = 1'b1;
        oldest_d = '0;
        count_d  = CW'(1);
        we       = 1'b1;
        waddr    = '0;
        wdata    = {seed_h_q, seed_req_q, seed_ft_q};
      end
    end

    // Issue one read per cycle over the live entries
    if (cmd_i.scan_rd && !issue_done) begin
      rd_vld_d  = 1'b1;
      rd_slot_d = raddr;
      rd_i_d    = rd_i_q + CW'(1);
    end

    // Min-merge into the first entry of equal height
    if (cmd_i.merge_wr && hit) begin
      merged_d = 1'b1;
      we       = 1'b1;
      waddr    = rd_slot_q;
      wdata    = {it_h_q,
                  (it_req_q < rd_req) ? it_req_q : rd_req,
                  (it_ft_q < rd_ft) ? it_ft_q : rd_ft};
    end

    // Append; a full store first loses its oldest entry
    if (cmd_i.append) begin
      we = 1'b1;
      if (full) begin
        waddr     = oldest_q;
        oldest_d  = slot_of(oldest_q, CW'(1));
        removed_d = CW'(1);
        ovf_d     = 1'b1;
      end else begin
        count_d = count_q + CW'(1);
      end
    end

    // Window mode: drop everything beyond the window at once
    if (cmd_i.trim && (cnt_x > win_x)) begin
      oldest_d  = slot_of(oldest_q, excess);
      removed_d = removed_q + excess;
      count_d   = CW'(win_x);
    end

    // Height mode: compact surviving entries toward the oldest slot
    if (cmd_i.purge_wr && rd_vld_q) begin
      if (keep) begin
        we     = 1'b1;
        waddr  = slot_of(oldest_q, kept_q);
        wdata  = rdata;
        kept_d = kept_q + CW'(1);
      end else begin
        removed_d = removed_q + CW'(1);
      end
    end
    if (cmd_i.purge_commit) begin
      count_d = kept_q;
    end

    // Minimum accumulation
    if (cmd_i.min_acc && rd_vld_q) begin
      if (rd_ft < min_ft_q) begin
        min_ft_d = rd_ft;
      end
      if (rd_req < min_req_q) begin
        min_req_d = rd_req;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seeded_q  <= 1'b0;
      oldest_q  <= '0;
      count_q   <= '0;
      removed_q <= '0;
      merged_q  <= 1'b0;
      ovf_q     <= 1'b0;
      rd_i_q    <= '0;
      rd_vld_q  <= 1'b0;
      kept_q    <= '0;
    end else begin
      seeded_q  <= seeded_d;
      oldest_q  <= oldest_d;
      count_q   <= count_d;
      removed_q <= removed_d;
      merged_q  <= merged_d;
      ovf_q     <= ovf_d;
      rd_i_q    <= rd_i_d;
      rd_vld_q  <= rd_vld_d;
      kept_q    <= kept_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_slot_q <= rd_slot_d;
    min_ft_q  <= min_ft_d;
    min_req_q <= min_req_d;
  end

  // Entry store
  fwmt_ram #(
    .Width (ENTRY_W),
    .Depth (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Result register
  logic out_vld_q;
  logic [OUT_TDATA_W-1:0] out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_data_q <= {{(OUT_TDATA_W - OUT_FIELDS_W){1'b0}},
                     ovf_q,
                     CNT_OUT_W'(removed_q),
                     merged_q,
                     CNT_OUT_W'(count_q),
                     min_req_q,
                     min_ft_q};
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

endmodule

`default_nettype wire

// File: src/fwmt_checker.sv
// Port-level checks for the fee window minimum tracker, bound to the top.
// Depends on fwmt_pkg.
`default_nettype none

module fwmt_checker (
  input wire logic                             clk_i,
  input wire logic                             rst_ni,
  input wire logic                             s_axis_tvalid,
  input wire logic                             s_axis_tready,
  input wire logic                             m_axis_tvalid,
  input wire logic                             m_axis_tready,
  input wire logic [fwmt_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import fwmt_pkg::*;

  logic                 o_merged, o_ovf;
  logic [CNT_OUT_W-1:0] o_count, o_removed;

  assign o_merged  = m_axis_tdata[OUT_MERGED_BIT];
  assign o_ovf     = m_axis_tdata[OUT_OVF_BIT];
  assign o_count   = m_axis_tdata[OUT_COUNT_LSB +: CNT_OUT_W];
  assign o_removed = m_axis_tdata[OUT_REMOVED_LSB +: CNT_OUT_W];

  // One request in flight: ready drops right after an accept
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("request accepted while another is in progress");

  // Store never reported empty
  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (o_count != '0))
    else $error("result reports an empty store");

  // A merge removes nothing
  a_merge_no_removal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && o_merged) |-> ((o_removed == '0) && !o_ovf))
    else $error("merged result reports removals");

  // A forced drop is counted
  a_ovf_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && o_ovf) |-> (o_removed != '0))
    else $error("overflow without removal count");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

endmodule

bind fee_window_minimum_tracker fwmt_checker u_fwmt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// File: verif/tb.sv
// Self-checking testbench for fee_window_minimum_tracker: directed and random fee updates.
// Depends on fwmt_pkg and the tracker RTL. It predicts every result with its own model of
// the ordered fee store.
`timescale 1ns / 100ps

module tb;
  import fwmt_pkg::*;

  localparam int unsigned DEPTH        = STORE_DEPTH_DEF;
  localparam int unsigned CLK_HALF     = 10;
  localparam int unsigned DRAIN_CYCLES = 3 * DEPTH + 16;
  localparam int unsigned PHASES       = 28;
  localparam int unsigned PHASE_ITEMS  = 50;
  localparam logic [HEIGHT_W-1:0] HEIGHT_MAX = {HEIGHT_W{1'b1}};

  typedef struct packed {
    logic [FEE_W-1:0]    ft_fee;
    logic [FEE_W-1:0]    req_fee;
    logic [HEIGHT_W-1:0] height;
  } fee_entry_t;

  typedef struct packed {
    logic [FEE_W-1:0]     min_ft_fee;
    logic [FEE_W-1:0]     min_req_fee;
    logic [CNT_OUT_W-1:0] entry_count;
    logic                 merged;
    logic [CNT_OUT_W-1:0] removed_count;
    logic                 overflow;
  } fee_report_t;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i     = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i    = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  // Predictor: register copies and the fee store, oldest entry first
  logic                   height_keyed  = 1'b0;
  logic [WIN_W-1:0]       span_reg      = 9'd1;
  logic [FEE_W-1:0]       seed_ft       = '0;
  logic [FEE_W-1:0]       seed_req      = '0;
  logic [HEIGHT_W-1:0]    seed_h        = '0;
  bit                     ledger_seeded = 1'b0;
  fee_entry_t             fee_ledger[$];
  fee_report_t            expected_reports[$];

  int unsigned            error_count   = 0;
  bit                     no_idle       = 1'b0;
  int unsigned            height_cursor = 1000;

  always #CLK_HALF clk_i = ~clk_i;

  fee_window_minimum_tracker uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Applies one fee update to the store and returns the report it should produce
  function automatic fee_report_t apply_fee_update(input logic [FEE_W-1:0] ft,
                                                   input logic [FEE_W-1:0] req,
                                                   input logic [HEIGHT_W-1:0] h);
    fee_report_t rep;
    fee_entry_t  kept[$];
    fee_entry_t  ent;
    int          hit;
    int unsigned span;
    int unsigned dropped;
    longint      age_limit;
    rep     = '0;
    hit     = -1;
    dropped = 0;
    span    = (span_reg == 0) ? 1 : span_reg;
    // first update after reset seeds the store from the seed registers
    if (!ledger_seeded) begin
      fee_ledger.delete();
      ent = {seed_ft, seed_req, seed_h};
      fee_ledger.push_back(ent);
      ledger_seeded = 1'b1;
    end
    // keyed by height: the oldest entry of the same height absorbs the update
    if (height_keyed) begin
      foreach (fee_ledger[i]) begin
        ent = fee_ledger[i];
        if (hit < 0 && ent.height == h) hit = i;
      end
    end
    if (hit >= 0) begin
      ent = fee_ledger[hit];
      if (ft < ent.ft_fee) ent.ft_fee = ft;
      if (req < ent.req_fee) ent.req_fee = req;
      fee_ledger[hit] = ent;
      rep.merged = 1'b1;
    end else begin
      // a full store loses its oldest entry before the append
      if (fee_ledger.size() >= DEPTH) begin
        fee_ledger.delete(0);
        dropped++;
        rep.overflow = 1'b1;
      end
      ent = {ft, req, h};
      fee_ledger.push_back(ent);
      if (height_keyed) begin
        // age purge; signed threshold so small heights purge nothing
        age_limit = longint'(h) - longint'(span);
        foreach (fee_ledger[i]) begin
          ent = fee_ledger[i];
          if (longint'(ent.height) > age_limit) kept.push_back(ent);
        end
        dropped += fee_ledger.size() - kept.size();
        fee_ledger = kept;
      end else begin
        while (fee_ledger.size() > span) begin
          fee_ledger.delete(0);
          dropped++;
        end
      end
    end
    // minima over what is left
    rep.min_ft_fee  = FEE_MAX;
    rep.min_req_fee = FEE_MAX;
    foreach (fee_ledger[i]) begin
      ent = fee_ledger[i];
      if (ent.ft_fee < rep.min_ft_fee) rep.min_ft_fee = ent.ft_fee;
      if (ent.req_fee < rep.min_req_fee) rep.min_req_fee = ent.req_fee;
    end
    rep.entry_count   = CNT_OUT_W'(fee_ledger.size());
    rep.removed_count = CNT_OUT_W'(dropped);
    return rep;
  endfunction

  function automatic int unsigned draw_gap();
    return no_idle ? 0 : $urandom_range(12, 0);
  endfunction

  // Fees: extremes, small values for ties, and full-width random
  function automatic logic [FEE_W-1:0] draw_fee();
    logic [63:0] raw;
    raw = {$urandom(), $urandom()};
    case ($urandom_range(7, 0))
      0:       return '0;
      1:       return FEE_MAX;
      2, 3:    return FEE_W'($urandom_range(15, 0));
      default: return raw[FEE_W-1:0];
    endcase
  endfunction

  // Heights: mostly a slowly rising chain with repeats, some stale and wild values
  function automatic logic [HEIGHT_W-1:0] draw_height();
    int unsigned pick;
    pick = $urandom_range(99, 0);
    if (pick < 2) return HEIGHT_W'($urandom());
    if (pick == 2) return HEIGHT_MAX;
    if (pick == 3) return '0;
    if (pick < 9) return HEIGHT_W'(height_cursor - $urandom_range(20, 0));
    if (pick >= 30) height_cursor += $urandom_range(3, 1);
    return HEIGHT_W'(height_cursor);
  endfunction

  function automatic logic [WIN_W-1:0] draw_window();
    int unsigned pick;
    pick = $urandom_range(99, 0);
    if (pick < 10) return '0;
    if (pick < 70) return WIN_W'($urandom_range(8, 1));
    if (pick < 92) return WIN_W'($urandom_range(40, 9));
    if (pick < 96) return WIN_W'(DEPTH);
    return WIN_W'($urandom_range(511, 41));
  endfunction

  // Register write; the block is idle whenever this is called
  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    case (idx)
      CFG_HEIGHT_MODE:  height_keyed = value[0];
      CFG_WINDOW_SIZE:  span_reg     = value[WIN_W-1:0];
      CFG_SEED_FT_FEE:  seed_ft      = value;
      CFG_SEED_REQ_FEE: seed_req     = value;
      CFG_SEED_HEIGHT:  seed_h       = value[HEIGHT_W-1:0];
      default: ;
    endcase
  endtask

  // Sends one request and records its expected report once accepted
  task automatic send_request(input logic [FEE_W-1:0] ft, input logic [FEE_W-1:0] req,
                              input logic [HEIGHT_W-1:0] h);
    int unsigned gap;
    gap = draw_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {h, req, ft};
    do @(posedge clk_i); while (!s_axis_tready);
    expected_reports.push_back(apply_fee_update(ft, req, h));
  endtask

  // Stops sending and waits until every expected report has come back
  task automatic await_results();
    s_axis_tvalid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk_i);
  endtask

  function automatic void compare_field(input string name, input logic [FEE_W-1:0] exp_v,
                                        input logic [FEE_W-1:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
      error_count++;
    end
  endfunction

  task automatic check_report(input logic [OUT_TDATA_W-1:0] beat);
    fee_report_t want;
    fee_report_t got;
    got.min_ft_fee    = beat[0 +: FEE_W];
    got.min_req_fee   = beat[OUT_MIN_REQ_LSB +: FEE_W];
    got.entry_count   = beat[OUT_COUNT_LSB +: CNT_OUT_W];
    got.merged        = beat[OUT_MERGED_BIT];
    got.removed_count = beat[OUT_REMOVED_LSB +: CNT_OUT_W];
    got.overflow      = beat[OUT_OVF_BIT];
    if (expected_reports.size() == 0) begin
      $display("%0t: result with no pending request: expected none, actual %h", $time, beat);
      error_count++;
    end else begin
      want = expected_reports[0];
      expected_reports.delete(0);
      compare_field("min_ft_fee", want.min_ft_fee, got.min_ft_fee);
      compare_field("min_req_fee", want.min_req_fee, got.min_req_fee);
      compare_field("entry_count", want.entry_count, got.entry_count);
      compare_field("merged", want.merged, got.merged);
      compare_field("removed_count", want.removed_count, got.removed_count);
      compare_field("overflow", want.overflow, got.overflow);
    end
  endtask

  // Result side: random stalls, sometimes only after a result is offered
  initial begin : result_sink
    int unsigned stall;
    bit          hold;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      stall = draw_gap();
      hold  = !no_idle && ($urandom_range(1, 0) == 1);
      if (stall != 0 || hold) m_axis_tready <= 1'b0;
      if (hold) do @(posedge clk_i); while (!m_axis_tvalid);
      repeat (stall) @(posedge clk_i);
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      check_report(m_axis_tdata);
    end
  end

  // Window mode: seeding, extreme fields, trimming, repeated heights
  task automatic test_window_trim();
    await_results();
    write_reg(CFG_HEIGHT_MODE, 0);
    write_reg(CFG_WINDOW_SIZE, 3);
    write_reg(CFG_SEED_FT_FEE, FEE_MAX);
    write_reg(CFG_SEED_REQ_FEE, '0);
    write_reg(CFG_SEED_HEIGHT, 7);
    send_request('0, FEE_MAX, HEIGHT_MAX);
    send_request(FEE_MAX, '0, '0);
    send_request(5, 9, 7);
    send_request(6, 4, 7);
    send_request(FEE_MAX, FEE_MAX, '0);
  endtask

  // Switch to height mode on the same store: merge into oldest duplicate, small heights
  task automatic test_height_merge();
    await_results();
    write_reg(CFG_HEIGHT_MODE, 1);
    send_request(3, 100, 7);
    send_request(2, 2, 2);
    send_request(1, 1, 9);
    send_request(10, 0, 9);
  endtask

  // Zero window acts as one in both modes; seed writes after seeding change nothing
  task automatic test_zero_window();
    await_results();
    write_reg(CFG_WINDOW_SIZE, 0);
    send_request(8, 8, 10);
    send_request('0, '0, HEIGHT_MAX);
    await_results();
    write_reg(CFG_HEIGHT_MODE, 0);
    write_reg(CFG_SEED_FT_FEE, '0);
    write_reg(CFG_SEED_REQ_FEE, FEE_MAX);
    write_reg(CFG_SEED_HEIGHT, HEIGHT_MAX);
    send_request(7, 7, HEIGHT_MAX);
    send_request(FEE_MAX, FEE_MAX, 1);
    send_request(4, 4, 1);
  endtask

  // Windows at or beyond the store depth: forced drops in window mode, a full collapse, then drops in height mode
  task automatic test_store_overflow();
    await_results();
    write_reg(CFG_WINDOW_SIZE, 511);
    repeat (DEPTH + 14) send_request(draw_fee(), draw_fee(), draw_height());
    await_results();
    write_reg(CFG_WINDOW_SIZE, 1);
    send_request(draw_fee(), draw_fee(), draw_height());
    await_results();
    write_reg(CFG_HEIGHT_MODE, 1);
    write_reg(CFG_WINDOW_SIZE, DEPTH);
    repeat (DEPTH + 14) begin
      height_cursor++;
      send_request(draw_fee(), draw_fee(), HEIGHT_W'(height_cursor));
    end
  endtask

  // Random phases, each with its own mode and window
  task automatic test_random_updates();
    for (int phase = 0; phase < PHASES; phase++) begin
      await_results();
      no_idle = (phase % 4 == 3);
      write_reg(CFG_HEIGHT_MODE, $urandom_range(1, 0));
      write_reg(CFG_WINDOW_SIZE, draw_window());
      if (phase % 7 == 0) begin
        write_reg(CFG_SEED_FT_FEE, draw_fee());
        write_reg(CFG_SEED_REQ_FEE, draw_fee());
        write_reg(CFG_SEED_HEIGHT, draw_height());
      end
      repeat (PHASE_ITEMS) send_request(draw_fee(), draw_fee(), draw_height());
    end
    no_idle = 1'b0;
  endtask

  initial begin : run_tests
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_window_trim();
    test_height_merge();
    test_zero_window();
    test_store_overflow();
    test_random_updates();
    await_results();
    // catch any stray result after the last one
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #(200_000_000);
    $display("Simulation FAILED");
    $finish;
  end

endmodule
